// ===== sv/spq_pkg.sv =====
// Shared types, constants and sizes of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int PRI_W    = 32;
    localparam int PAY_W    = 16;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_PUSH_WALK = 6'b000010,
        ST_PUSH_PUT  = 6'b000100,
        ST_POP_HEAD  = 6'b001000,
        ST_POP_SHIFT = 6'b010000,
        ST_DONE      = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/spq_req_if.sv =====
// Request channel: one queue operation per word.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::MODE_W-1:0]      mode;
    logic [spq_pkg::PRI_W-1:0]       priority_req;
    logic [spq_pkg::PAY_W-1:0]       payload;

    modport source (output valid, output mode, output priority_req, output payload,
                    input ready);
    modport sink (input valid, input mode, input priority_req, input payload,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/spq_rsp_if.sv =====
// Response channel: one result word per queue operation.
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::PAY_W-1:0]       result_data;
    logic [spq_pkg::STATUS_W-1:0]    status;
    logic [spq_pkg::COUNT_W-1:0]     count;

    modport source (output valid, output result_data, output status, output count,
                    input ready);
    modport sink (input valid, input result_data, input status, input count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/spq_mem.sv =====
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spq_mem (
    input  wire logic              clk,
    input  wire spq_pkg::mem_req_t req,
    output spq_pkg::entry_t        rdata
);

    spq_pkg::entry_t mem [spq_pkg::DEPTH];
    spq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/spq_cmp.sv =====
// Ordering compare: is a stored entry strictly after a new entry.
`timescale 1ns / 1ps
`default_nettype none

module spq_cmp (
    input  wire spq_pkg::entry_t stored,
    input  wire spq_pkg::entry_t fresh,
    output logic                 greater
);

    always_comb
    begin
        greater = (stored.pri > fresh.pri) ||
                  ((stored.pri == fresh.pri) && (stored.pay > fresh.pay));
    end

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted priority queue: a bounded queue of entries held in ascending order of
// priority, ties broken by ascending payload, with push, pop and peek words.
// Entries sit in a memory with one write port and one registered read port, walked
// one entry per cycle by a small sequencer and one comparator. A push walks
// from the tail toward the head, moving each greater entry down one place until its
// slot is found. A pop reads the head and moves the rest up one place; a peek reads
// the head only, and a refused operation or mode 3 goes straight to its result. A
// finished result waits in an output register, so the next word is taken while the
// previous result has not yet been collected; if that result is still waiting when
// the next operation finishes, the sequencer holds in its last step until it is
// taken. Mode 3 does nothing and reports status ok with the current count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    spq_pkg::state_t                    state_reg, state_next;
    logic [spq_pkg::CNT_W-1:0]          fill_reg, fill_next;
    logic [spq_pkg::IDX_W-1:0]          ptr_reg, ptr_next;
    logic [spq_pkg::MODE_W-1:0]         op_reg, op_next;
    logic [spq_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [spq_pkg::PAY_W-1:0]          data_reg, data_next;
    spq_pkg::entry_t                    new_reg, new_next;
    logic                               out_valid_reg, out_valid_next;
    logic [spq_pkg::PAY_W-1:0]          out_data_reg, out_data_next;
    logic [spq_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [spq_pkg::COUNT_W-1:0]        out_count_reg, out_count_next;

    spq_pkg::mem_req_t                  mem_req;
    spq_pkg::entry_t                    rdata;
    logic                               greater;

    spq_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    spq_cmp u_cmp (
        .stored  (rdata),
        .fresh   (new_reg),
        .greater (greater)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        new_next        = new_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = ptr_reg;
        mem_req.wdata   = new_reg;
        mem_req.raddr   = '0;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                // Start the read at the tail for a push, at the head otherwise.
                if (req.mode == spq_pkg::MODE_PUSH)
                begin
                    mem_req.raddr = spq_pkg::IDX_W'(fill_reg - 1'b1);
                end
                if (req.valid)
                begin
                    op_next     = req.mode;
                    new_next    = '{pri: req.priority_req, pay: req.payload};
                    data_next   = '0;
                    status_next = spq_pkg::STATUS_OK;
                    ptr_next    = spq_pkg::IDX_W'(fill_reg - 1'b1);
                    unique case (req.mode)
                        spq_pkg::MODE_PUSH:
                        begin
                            if (fill_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH))
                            begin
                                status_next = spq_pkg::STATUS_FULL;
                                state_next  = spq_pkg::ST_DONE;
                            end
                            else if (fill_reg == '0)
                            begin
                                ptr_next   = '0;
                                state_next = spq_pkg::ST_PUSH_PUT;
                            end
                            else
                            begin
                                state_next = spq_pkg::ST_PUSH_WALK;
                            end
                        end
                        spq_pkg::MODE_POP, spq_pkg::MODE_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = spq_pkg::STATUS_EMPTY;
                                state_next  = spq_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = spq_pkg::ST_POP_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = spq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            spq_pkg::ST_PUSH_WALK:
            begin
                // rdata holds the entry at ptr; the entry below it is read meanwhile.
                mem_req.raddr = ptr_reg - 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg + 1'b1;
                if (greater)
                begin
                    mem_req.wdata = rdata;
                    if (ptr_reg == '0)
                    begin
                        state_next = spq_pkg::ST_PUSH_PUT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
                else
                begin
                    mem_req.wdata = new_reg;
                    state_next    = spq_pkg::ST_DONE;
                end
            end

            spq_pkg::ST_PUSH_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                mem_req.wdata = new_reg;
                state_next    = spq_pkg::ST_DONE;
            end

            spq_pkg::ST_POP_HEAD:
            begin
                data_next     = rdata.pay;
                mem_req.raddr = spq_pkg::IDX_W'(1);
                if (op_reg == spq_pkg::MODE_POP && fill_reg > spq_pkg::CNT_W'(1))
                begin
                    ptr_next   = spq_pkg::IDX_W'(1);
                    state_next = spq_pkg::ST_POP_SHIFT;
                end
                else
                begin
                    state_next = spq_pkg::ST_DONE;
                end
            end

            spq_pkg::ST_POP_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg - 1'b1;
                mem_req.wdata = rdata;
                mem_req.raddr = ptr_reg + 1'b1;
                if (ptr_reg == spq_pkg::IDX_W'(fill_reg - 1'b1))
                begin
                    state_next = spq_pkg::ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            spq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    if (status_reg == spq_pkg::STATUS_OK && op_reg == spq_pkg::MODE_PUSH)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else if (status_reg == spq_pkg::STATUS_OK &&
                             op_reg == spq_pkg::MODE_POP)
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_data_next   = data_reg;
                    out_status_next = status_reg;
                    out_count_next  = spq_pkg::COUNT_W'(fill_next);
                    state_next      = spq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        new_reg        <= new_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign req.ready       = (state_reg == spq_pkg::ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_data = out_data_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.count       = out_count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("fill count beyond queue depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == spq_pkg::STATUS_FULL
            |-> rsp.count == spq_pkg::COUNT_W'(spq_pkg::DEPTH))
        else $error("full status with a queue that is not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == spq_pkg::STATUS_EMPTY
            |-> rsp.count == '0 && rsp.result_data == '0)
        else $error("empty status with stored entries or nonzero data");

    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> state_reg != spq_pkg::ST_IDLE && state_reg != spq_pkg::ST_DONE)
        else $error("entry memory written outside an operation");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == spq_pkg::ST_DONE))
        else $error("result word raised without a finished operation");

endmodule

`default_nettype wire
